// ===== rtl/keypad_ir_remote_encoder_macros.svh =====
// Assertion macros shared by the encoder modules.
`ifndef KEYPAD_IR_REMOTE_ENCODER_MACROS_SVH
`define KEYPAD_IR_REMOTE_ENCODER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define KIR_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed: invariant");

// A consequence in the same cycle.
`define KIR_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// A consequence in the following cycle.
`define KIR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/kir_pkg.sv =====
package kir_pkg;

    localparam int KEY_ROWS  = 6;
    localparam int KEY_COLS  = 6;
    localparam int KEY_BITS  = KEY_ROWS * KEY_COLS;
    localparam int KEY_IDX_W = $clog2(KEY_ROWS * KEY_COLS);
    localparam int COL_POS_W = $clog2(KEY_COLS);
    localparam int ROM_SIZE  = 36;
    localparam int CODE_W    = 8;
    localparam int UNITS_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;

    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam int STEP_W          = 6;
    localparam int BIT_STEP_FIRST  = 2;
    localparam int BIT_STEP_LAST   = BIT_STEP_FIRST + 4 * CODE_W - 1;
    localparam int STOP_MARK_STEP  = BIT_STEP_LAST + 1;
    localparam int STOP_SPACE_STEP = BIT_STEP_LAST + 2;
    localparam int SEG_LAST_STEP   = BIT_STEP_LAST + 3;
    localparam int WORD_W          = 2 * CODE_W;
    localparam int BIT_SEL_W       = $clog2(2 * CODE_W);

    localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SPACE  = 3'd5;

    localparam logic [CFG_W-1:0] RST_SYSTEM_CODE = 8'h02;
    localparam logic [CFG_W-1:0] RST_HEADER      = 8'd114;
    localparam logic [CFG_W-1:0] RST_BIT_MARK    = 8'd19;
    localparam logic [CFG_W-1:0] RST_ONE_SPACE   = 8'd95;
    localparam logic [CFG_W-1:0] RST_ZERO_SPACE  = 8'd57;
    localparam logic [CFG_W-1:0] RST_STOP_SPACE  = 8'd152;

    localparam logic [CODE_W-1:0] CODE_ROM [ROM_SIZE] = '{
        8'h14, 8'h0B, 8'h01, 8'h02, 8'h03, 8'h04,
        8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
        8'h00, 8'h0E, 8'h0D, 8'h1E, 8'h1D, 8'h15,
        8'h11, 8'h30, 8'h12, 8'h2F, 8'h13, 8'h10,
        8'h1C, 8'h1A, 8'h19, 8'h20, 8'h0C, 8'h1F,
        8'h21, 8'h16, 8'h17, 8'h18, 8'h0F, 8'h1B
    };

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_INVALID = 2'd1,
        KIND_MARK    = 2'd2,
        KIND_SPACE   = 2'd3
    } seg_kind_t;

    typedef enum logic [1:0] {
        JOB_NONE    = 2'd0,
        JOB_INVALID = 2'd1,
        JOB_SEND    = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [CODE_W-1:0] code;
    } job_t;

    typedef struct packed {
        logic [CFG_W-1:0] system_code;
        logic [CFG_W-1:0] header_units;
        logic [CFG_W-1:0] bit_mark_units;
        logic [CFG_W-1:0] one_space_units;
        logic [CFG_W-1:0] zero_space_units;
        logic [CFG_W-1:0] stop_space_units;
    } cfg_t;

endpackage

// ===== rtl/kir_front.sv =====
module kir_front
    import kir_pkg::*;
(
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KEY_BITS-1:0] s_key_matrix,
    input  logic                q_full,
    output logic                q_push,
    output job_t                q_job
);

    logic [KEY_COLS-1:0]  row_bits  [KEY_ROWS];
    logic                 row_one   [KEY_ROWS];
    logic                 row_many  [KEY_ROWS];
    logic [COL_POS_W-1:0] row_pos   [KEY_ROWS];
    logic                 found;
    logic                 invalid;
    logic [KEY_IDX_W-1:0] key_idx;
    logic                 in_rom;

    always_comb begin
        for (int r = 0; r < KEY_ROWS; r++) begin
            row_bits[r] = s_key_matrix[r*KEY_COLS +: KEY_COLS];
            row_many[r] = (row_bits[r] & (row_bits[r] - 1'b1)) != '0;
            row_one[r]  = (row_bits[r] != '0) && !row_many[r];
            row_pos[r]  = '0;
            for (int c = KEY_COLS - 1; c >= 0; c--) begin
                if (row_bits[r][c]) begin
                    row_pos[r] = COL_POS_W'(c);
                end
            end
        end
    end

    always_comb begin
        found   = 1'b0;
        invalid = 1'b0;
        key_idx = '0;
        if (row_one[0]) begin
            found   = 1'b1;
            key_idx = KEY_IDX_W'(row_pos[0]);
        end else if (row_many[0]) begin
            invalid = 1'b1;
        end else begin
            for (int r = 1; r < KEY_ROWS; r++) begin
                if (row_many[r] || (row_one[r] && found)) begin
                    invalid = 1'b1;
                end else if (row_one[r]) begin
                    found   = 1'b1;
                    key_idx = KEY_IDX_W'(r * KEY_COLS + int'(row_pos[r]));
                end
            end
        end
    end

    always_comb begin
        in_rom     = int'(key_idx) < ROM_SIZE;
        q_job.code = '0;
        if (invalid) begin
            q_job.kind = JOB_INVALID;
        end else if (found) begin
            q_job.kind = JOB_SEND;
            if (in_rom) begin
                q_job.code = CODE_ROM[key_idx];
            end
        end else begin
            q_job.kind = JOB_NONE;
        end
    end

    // A key with no code entry is taken but causes no request downstream.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && (invalid || !found || in_rom);

endmodule

// ===== rtl/kir_queue.sv =====
`include "keypad_ir_remote_encoder_macros.svh"

module kir_queue
    import kir_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_pop;

    assign full       = count_reg == Q_CNT_W'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `KIR_ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= Q_CNT_W'(Q_DEPTH))
    `KIR_ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, push, !full || do_pop)

endmodule

// ===== rtl/kir_frame.sv =====
`include "keypad_ir_remote_encoder_macros.svh"

module kir_frame
    import kir_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               head_valid,
    input  job_t               head_job,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_segment_kind,
    output logic [UNITS_W-1:0] m_segment_units,
    output logic               m_last_segment
);

    logic                 m_valid_reg;
    seg_kind_t            m_kind_reg;
    logic [UNITS_W-1:0]   m_units_reg;
    logic                 m_last_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;

    seg_kind_t            seg_kind;
    logic [UNITS_W-1:0]   seg_units;
    logic                 seg_last;
    logic                 out_free;
    logic                 advance;
    logic [STEP_W-1:0]    bit_off;
    logic [BIT_SEL_W-1:0] bit_sel;
    logic [WORD_W-1:0]    frame_word;
    logic                 bit_val;
    logic                 out_is_status;

    assign out_free   = !m_valid_reg || m_ready;
    assign advance    = head_valid && out_free;
    assign pop        = advance && seg_last;
    assign frame_word = {cfg.system_code, head_job.code};
    assign bit_off    = step_reg - STEP_W'(BIT_STEP_FIRST);
    assign bit_sel    = BIT_SEL_W'(WORD_W - 1) - bit_off[BIT_SEL_W:1];
    assign bit_val    = frame_word[bit_sel];

    always_comb begin
        seg_kind  = KIND_NONE;
        seg_units = '0;
        seg_last  = 1'b1;
        unique case (head_job.kind)
            JOB_NONE: begin
                seg_kind = KIND_NONE;
            end
            JOB_INVALID: begin
                seg_kind = KIND_INVALID;
            end
            JOB_SEND: begin
                seg_last = 1'b0;
                if (step_reg == '0) begin
                    seg_kind  = KIND_MARK;
                    seg_units = cfg.header_units;
                end else if (step_reg < STEP_W'(BIT_STEP_FIRST)) begin
                    seg_kind  = KIND_SPACE;
                    seg_units = cfg.header_units;
                end else if (step_reg <= STEP_W'(BIT_STEP_LAST)) begin
                    if (!bit_off[0]) begin
                        seg_kind  = KIND_MARK;
                        seg_units = cfg.bit_mark_units;
                    end else begin
                        seg_kind  = KIND_SPACE;
                        seg_units = bit_val ? cfg.one_space_units : cfg.zero_space_units;
                    end
                end else if (step_reg == STEP_W'(STOP_MARK_STEP)) begin
                    seg_kind  = KIND_MARK;
                    seg_units = cfg.bit_mark_units;
                end else if (step_reg == STEP_W'(STOP_SPACE_STEP)) begin
                    seg_kind  = KIND_SPACE;
                    seg_units = cfg.stop_space_units;
                end else begin
                    seg_kind  = KIND_MARK;
                    seg_units = cfg.bit_mark_units;
                    seg_last  = 1'b1;
                end
            end
            default: begin
                seg_kind = KIND_NONE;
            end
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (advance) begin
            step_next = seg_last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            step_reg <= step_next;
            if (out_free) begin
                m_valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_kind_reg  <= seg_kind;
            m_units_reg <= seg_units;
            m_last_reg  <= seg_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_segment_kind  = m_kind_reg;
    assign m_segment_units = m_units_reg;
    assign m_last_segment  = m_last_reg;

    assign out_is_status = m_valid_reg && (m_kind_reg == KIND_NONE || m_kind_reg == KIND_INVALID);

    `KIR_ASSERT_ALWAYS(a_step_range, aclk, aresetn, step_reg <= STEP_W'(SEG_LAST_STEP))
    `KIR_ASSERT_IMPLIES(a_step_holds_item, aclk, aresetn, step_reg != '0, head_valid)
    `KIR_ASSERT_NEXT(a_pop_ends_scan, aclk, aresetn, pop, m_valid_reg && m_last_reg)
    `KIR_ASSERT_IMPLIES(a_status_is_last, aclk, aresetn, out_is_status, m_last_reg)

endmodule

// ===== rtl/keypad_ir_remote_encoder.sv =====
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_key_matrix (36 bits, one key scan)
// m_        out        m_valid / m_ready   m_segment_kind, m_segment_units, m_last_segment
// cfg_      in         cfg_we (no wait)    cfg_idx, cfg_wdata
//
// A key press frame is 37 segments on the output channel, one segment per cycle while m_ready
// is high; a status request is a single segment. The segment sequencer sets this sequence.
// The scan classifier takes one scan per cycle into a two-entry queue, so scans
// are accepted while a frame is still being sent, until the queue is full.
// Reset is synchronous and active low; it empties the queue and restores the registers.
// A stalled output holds its segment; the classifier stalls only on a full queue.
module keypad_ir_remote_encoder
    import kir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KEY_BITS-1:0]  s_key_matrix,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_segment_kind,
    output logic [UNITS_W-1:0]   m_segment_units,
    output logic                 m_last_segment,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    job_t q_job;
    logic q_pop;
    logic head_valid;
    job_t head_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.system_code      <= RST_SYSTEM_CODE;
            cfg_reg.header_units     <= RST_HEADER;
            cfg_reg.bit_mark_units   <= RST_BIT_MARK;
            cfg_reg.one_space_units  <= RST_ONE_SPACE;
            cfg_reg.zero_space_units <= RST_ZERO_SPACE;
            cfg_reg.stop_space_units <= RST_STOP_SPACE;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_SYSTEM_CODE: cfg_reg.system_code      <= cfg_wdata;
                REG_HEADER:      cfg_reg.header_units     <= cfg_wdata;
                REG_BIT_MARK:    cfg_reg.bit_mark_units   <= cfg_wdata;
                REG_ONE_SPACE:   cfg_reg.one_space_units  <= cfg_wdata;
                REG_ZERO_SPACE:  cfg_reg.zero_space_units <= cfg_wdata;
                REG_STOP_SPACE:  cfg_reg.stop_space_units <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    kir_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_matrix (s_key_matrix),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    kir_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    kir_frame u_frame (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .head_valid      (head_valid),
        .head_job        (head_job),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_segment_kind  (m_segment_kind),
        .m_segment_units (m_segment_units),
        .m_last_segment  (m_last_segment)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import kir_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_SCANS = 43;
    localparam int N_DIRECTED   = 19;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam logic [7:0] KEY_CODE_TAB [36] = '{
        8'h14, 8'h0B, 8'h01, 8'h02, 8'h03, 8'h04,
        8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
        8'h00, 8'h0E, 8'h0D, 8'h1E, 8'h1D, 8'h15,
        8'h11, 8'h30, 8'h12, 8'h2F, 8'h13, 8'h10,
        8'h1C, 8'h1A, 8'h19, 8'h20, 8'h0C, 8'h1F,
        8'h21, 8'h16, 8'h17, 8'h18, 8'h0F, 8'h1B
    };

    typedef struct packed {
        seg_kind_t          kind;
        logic [UNITS_W-1:0] units;
        logic               last;
    } ir_seg_t;

    // A row with status set carries its one status result; the others are predicted.
    typedef struct packed {
        logic [KEY_BITS-1:0] keys;
        logic                status;
        seg_kind_t           kind;
    } scan_row_t;

    localparam scan_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        {36'h0_0000_0000, 1'b1, KIND_NONE},
        {36'hF_FFFF_FFFF, 1'b1, KIND_INVALID},
        {36'h0_0000_0001, 1'b0, KIND_MARK},
        {36'h0_0000_0020, 1'b0, KIND_MARK},
        {36'h0_0000_0021, 1'b1, KIND_INVALID},
        {36'h0_0000_003F, 1'b1, KIND_INVALID},
        {36'hF_FFFF_FFC4, 1'b0, KIND_MARK},
        {36'h0_0000_0040, 1'b0, KIND_MARK},
        {36'h8_0000_0000, 1'b0, KIND_MARK},
        {36'h0_000C_0000, 1'b1, KIND_INVALID},
        {36'h0_4000_0040, 1'b1, KIND_INVALID},
        {36'h0_0080_1000, 1'b1, KIND_INVALID},
        {36'h0_3F00_0000, 1'b1, KIND_INVALID},
        {36'h0_0008_0000, 1'b0, KIND_MARK},
        {36'h0_0000_1000, 1'b0, KIND_MARK},
        {36'h0_0020_0000, 1'b0, KIND_MARK},
        {36'hF_FFFF_FFC0, 1'b1, KIND_INVALID},
        {36'h0_4000_0000, 1'b0, KIND_MARK},
        {36'h0_2000_0000, 1'b0, KIND_MARK}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [KEY_BITS-1:0]  s_key_matrix = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_segment_kind;
    logic [UNITS_W-1:0]   m_segment_units;
    logic                 m_last_segment;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    cfg_t    ir_cfg;
    ir_seg_t pending_segs [$];
    int      mismatches = 0;
    int      burst_left = 0;
    int      hold_reqs = 0;
    int      hold_acks = 0;
    int      hold_left = 0;
    int      rx_mode = 0;
    int      rx_mode_left = 0;
    int      rx_tick = 0;
    int      idle_cycles = 0;

    keypad_ir_remote_encoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_matrix    (s_key_matrix),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_segment_kind  (m_segment_kind),
        .m_segment_units (m_segment_units),
        .m_last_segment  (m_last_segment),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void push_seg(seg_kind_t kind, logic [UNITS_W-1:0] units, logic last);
        ir_seg_t seg;
        seg.kind  = kind;
        seg.units = units;
        seg.last  = last;
        pending_segs.push_back(seg);
    endfunction

    function automatic void push_byte(logic [7:0] value);
        for (int b = 7; b >= 0; b--) begin
            push_seg(KIND_MARK, ir_cfg.bit_mark_units, 1'b0);
            push_seg(KIND_SPACE, value[b] ? ir_cfg.one_space_units : ir_cfg.zero_space_units,
                     1'b0);
        end
    endfunction

    function automatic int lowest_col(logic [KEY_COLS-1:0] row);
        int pos;
        pos = 0;
        for (int c = KEY_COLS - 1; c >= 0; c--) begin
            if (row[c]) begin
                pos = c;
            end
        end
        return pos;
    endfunction

    function automatic void encode_scan(logic [KEY_BITS-1:0] keys);
        logic [KEY_COLS-1:0] row;
        int                  key_idx;
        bit                  found;
        bit                  invalid;
        key_idx = 0;
        found   = 1'b0;
        invalid = 1'b0;
        row     = keys[KEY_COLS-1:0];
        if ($countones(row) == 1) begin
            key_idx = lowest_col(row);
            found   = 1'b1;
        end else if ($countones(row) > 1) begin
            invalid = 1'b1;
        end else begin
            for (int r = 1; r < KEY_ROWS && !invalid; r++) begin
                row = keys[r*KEY_COLS +: KEY_COLS];
                if ($countones(row) > 1 || ($countones(row) == 1 && found)) begin
                    invalid = 1'b1;
                end else if ($countones(row) == 1) begin
                    key_idx = r * KEY_COLS + lowest_col(row);
                    found   = 1'b1;
                end
            end
        end
        if (invalid) begin
            push_seg(KIND_INVALID, '0, 1'b1);
        end else if (!found) begin
            push_seg(KIND_NONE, '0, 1'b1);
        end else begin
            push_seg(KIND_MARK, ir_cfg.header_units, 1'b0);
            push_seg(KIND_SPACE, ir_cfg.header_units, 1'b0);
            push_byte(ir_cfg.system_code);
            push_byte(KEY_CODE_TAB[key_idx]);
            push_seg(KIND_MARK, ir_cfg.bit_mark_units, 1'b0);
            push_seg(KIND_SPACE, ir_cfg.stop_space_units, 1'b0);
            push_seg(KIND_MARK, ir_cfg.bit_mark_units, 1'b1);
        end
    endfunction

    function automatic logic [KEY_BITS-1:0] random_scan();
        logic [KEY_BITS-1:0] scan;
        logic [63:0]         wide;
        int                  pick;
        int                  ra;
        int                  rb;
        int                  ca;
        pick = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        scan = '0;
        if (pick < 55) begin
            scan[$urandom_range(0, KEY_BITS - 1)] = 1'b1;
        end else if (pick < 65) begin
            scan = wide[KEY_BITS-1:0];
            scan[KEY_COLS-1:0] = '0;
            scan[$urandom_range(0, KEY_COLS - 1)] = 1'b1;
        end else if (pick < 72) begin
            scan = '0;
        end else if (pick < 80) begin
            ra = $urandom_range(0, KEY_ROWS - 1);
            ca = $urandom_range(0, KEY_COLS - 1);
            scan[ra*KEY_COLS + ca] = 1'b1;
            scan[ra*KEY_COLS + (ca + $urandom_range(1, KEY_COLS - 1)) % KEY_COLS] = 1'b1;
        end else if (pick < 88) begin
            ra = $urandom_range(1, KEY_ROWS - 1);
            rb = 1 + (ra - 1 + $urandom_range(1, KEY_ROWS - 2)) % (KEY_ROWS - 1);
            scan[ra*KEY_COLS + $urandom_range(0, KEY_COLS - 1)] = 1'b1;
            scan[rb*KEY_COLS + $urandom_range(0, KEY_COLS - 1)] = 1'b1;
        end else begin
            scan = wide[KEY_BITS-1:0];
        end
        return scan;
    endfunction

    task automatic offer_scan(logic [KEY_BITS-1:0] keys, logic status, seg_kind_t kind);
        logic [63:0] wide;
        s_valid      <= 1'b1;
        s_key_matrix <= keys;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (status) begin
            push_seg(kind, '0, 1'b1);
        end else begin
            encode_scan(keys);
        end
        if (burst_left == 0) begin
            wide = {$urandom, $urandom};
            s_valid      <= 1'b0;
            s_key_matrix <= wide[KEY_BITS-1:0];
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 30);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_segs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Writes to the unmapped indexes must leave every register untouched.
    task automatic load_settings(cfg_t next_cfg);
        write_reg(REG_UNMAPPED_LO, CFG_W'($urandom));
        write_reg(REG_SYSTEM_CODE, next_cfg.system_code);
        write_reg(REG_HEADER, next_cfg.header_units);
        write_reg(REG_BIT_MARK, next_cfg.bit_mark_units);
        write_reg(REG_ONE_SPACE, next_cfg.one_space_units);
        write_reg(REG_ZERO_SPACE, next_cfg.zero_space_units);
        write_reg(REG_STOP_SPACE, next_cfg.stop_space_units);
        write_reg(REG_UNMAPPED_HI, CFG_W'($urandom));
        cfg_we <= 1'b0;
        ir_cfg = next_cfg;
    endtask

    always @(posedge aclk) begin : result_check
        ir_seg_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_segs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected segment: kind %0d units %0d last %0d",
                                 m_segment_kind, m_segment_units, m_last_segment);
                    end
                end else begin
                    want = pending_segs.pop_front();
                    if (m_segment_kind !== want.kind || m_segment_units !== want.units
                            || m_last_segment !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Segment mismatch: expected kind %0d units %0d last %0d,",
                                     want.kind, want.units, want.last,
                                     " got kind %0d units %0d last %0d",
                                     m_segment_kind, m_segment_units, m_last_segment);
                        end
                    end
                end
            end
            if (hold_reqs != hold_acks) begin
                hold_acks = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(20, 200);
                end else begin
                    rx_mode_left--;
                end
                case (rx_mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_ready <= (rx_tick % 3 == 0);
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        cfg_t next_cfg;
        ir_cfg = '{8'h02, 8'd114, 8'd19, 8'd95, 8'd57, 8'd152};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(0, 30);
        for (int phase = 0; phase < 7; phase++) begin
            if (phase > 0) begin
                wait_drained();
                case (phase)
                    1: next_cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                    2: next_cfg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
                    3: next_cfg = '{8'hA5, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01};
                    default: begin
                        next_cfg = '{8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 8'($urandom), 8'($urandom)};
                    end
                endcase
                load_settings(next_cfg);
            end
            if (phase == 0) begin
                for (int i = 0; i < N_DIRECTED; i++) begin
                    offer_scan(DIRECTED_ROWS[i].keys, DIRECTED_ROWS[i].status,
                               DIRECTED_ROWS[i].kind);
                end
            end
            for (int n = 0; n < RANDOM_SCANS; n++) begin
                if (phase == 1 && n == 3) begin
                    hold_reqs++;
                end
                if (phase == 4 && n == 20) begin
                    wait_drained();
                end
                offer_scan(random_scan(), 1'b0, KIND_MARK);
            end
        end
        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_segs.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
